>>> rtl/smfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack map frame parser package
// Shared types, codes and the frame tag decode for the parser front and back.
// ----------------------------------------------------------------------------
package smfp_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [7:0] TagLocals1Base = 8'd64;
  localparam logic [7:0] TagReserved    = 8'd128;
  localparam logic [7:0] TagLocals1Ext  = 8'd247;
  localparam logic [7:0] TagSameExt     = 8'd251;
  localparam logic [7:0] TagFull        = 8'd255;
  localparam logic [7:0] VtObject       = 8'd7;
  localparam logic [7:0] VtUninit       = 8'd8;

  typedef enum logic [2:0] {
    KIND_SAME       = 3'd0,
    KIND_LOC1       = 3'd1,
    KIND_LOC1_EXT   = 3'd2,
    KIND_CHOP       = 3'd3,
    KIND_SAME_EXT   = 3'd4,
    KIND_APPEND     = 3'd5,
    KIND_FULL       = 3'd6,
    KIND_INVALID    = 3'd7
  } frame_kind_t;

  typedef enum logic [3:0] {
    PH_CNT_HI   = 4'd0,
    PH_CNT_LO   = 4'd1,
    PH_TAG      = 4'd2,
    PH_DELTA_HI = 4'd3,
    PH_DELTA_LO = 4'd4,
    PH_NLOC_HI  = 4'd5,
    PH_NLOC_LO  = 4'd6,
    PH_VTAG     = 4'd7,
    PH_VSKIP    = 4'd8,
    PH_NSTK_HI  = 4'd9,
    PH_NSTK_LO  = 4'd10,
    PH_IDLE     = 4'd11
  } phase_t;

  // One classified byte as it travels from the front to the back.
  typedef struct packed {
    logic [7:0]  data;
    logic        start;
    frame_kind_t tag_kind;  // meaning of the byte if it is a frame tag
    logic        vt_ext;    // Object or Uninitialized verification tag
    logic        vt_bad;    // verification tag above the defined range
  } smfp_item_t;

  typedef struct packed {
    frame_kind_t kind;
    logic [7:0]  tag;
    logic [15:0] delta;
    logic [15:0] index;
    logic [16:0] entries;
    logic        bad;
    logic        last;
  } smfp_result_t;

  function automatic frame_kind_t classify_tag(input logic [7:0] b);
    frame_kind_t k;
    if (b < TagLocals1Base)     k = KIND_SAME;
    else if (b < TagReserved)   k = KIND_LOC1;
    else if (b < TagLocals1Ext) k = KIND_INVALID;
    else if (b == TagLocals1Ext) k = KIND_LOC1_EXT;
    else if (b < TagSameExt)    k = KIND_CHOP;
    else if (b == TagSameExt)   k = KIND_SAME_EXT;
    else if (b < TagFull)       k = KIND_APPEND;
    else                        k = KIND_FULL;
    return k;
  endfunction

endpackage

>>> rtl/stack_map_frame_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack map frame parser
// Parses a class-file stack map table byte stream into one result per frame.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one table byte per beat in s_tdata; s_tuser marks
//   the first frame-count byte of a new table and restarts the parser there.
//   The master channel gives one beat per completed frame: kind and the bad
//   verification tag flag in m_tuser, tag, delta, index and entry count in
//   m_tdata, and m_tlast on the final frame of the table. Bytes that do not
//   finish a frame give no beat; bytes after the last frame are dropped.
//   Throughput is one byte per cycle while no stalled result holds the back
//   end, set by its single-byte parser step. A result shows on the master
//   side once the beat that finishes its frame has passed through the
//   four-entry byte queue and the result register. When the receiver stalls,
//   the result register holds and the queue absorbs up to four more bytes
//   before s_tready drops. Reset is synchronous and empties the queue and the
//   result register; the parser then waits for the count high byte.
// ----------------------------------------------------------------------------
module stack_map_frame_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic [0:0]  s_tuser,   // [0] table_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [7:0] frame_tag, [23:8] pc_delta,
                                 // [39:24] frame_index, [56:40] type_entries,
                                 // [63:57] zero
  output logic [3:0]  m_tuser,   // [2:0] frame_kind, [3] bad_type_tag
  output logic        m_tlast    // last_frame
);
  import smfp_pkg::*;

  smfp_item_t   front_item;
  smfp_item_t   head_item;
  smfp_result_t res;
  logic         q_full;
  logic         q_not_empty;
  logic         q_pop;
  logic         push;

  // The front decodes the byte as it arrives; the queue lets it keep
  // accepting while the back waits on a stalled result.
  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  smfp_front u_front (
    .in_byte  (s_tdata),
    .in_start (s_tuser[0]),
    .item     (front_item)
  );

  smfp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_item (head_item)
  );

  smfp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (q_not_empty),
    .item       (head_item),
    .item_pop   (q_pop),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready),
    .res        (res)
  );

  assign m_tdata = {7'd0, res.entries, res.index, res.delta, res.tag};
  assign m_tuser = {res.bad, res.kind};
  assign m_tlast = res.last;

endmodule

>>> rtl/smfp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack map frame parser front
// Decodes each incoming byte both as a frame tag and as a verification tag.
// ----------------------------------------------------------------------------
module smfp_front (
  input  logic [7:0]          in_byte,
  input  logic                in_start,
  output smfp_pkg::smfp_item_t item
);
  import smfp_pkg::*;

  always_comb begin
    item.data     = in_byte;
    item.start    = in_start;
    item.tag_kind = classify_tag(in_byte);
    item.vt_ext   = (in_byte == VtObject) || (in_byte == VtUninit);
    item.vt_bad   = (in_byte > VtUninit);
  end

endmodule

>>> rtl/smfp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack map frame parser queue
// Short FIFO of classified bytes between the front and the back.
// ----------------------------------------------------------------------------
module smfp_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  smfp_pkg::smfp_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output logic                 not_empty,
  output smfp_pkg::smfp_item_t head_item
);
  import smfp_pkg::*;

  smfp_item_t             slots [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr;
  logic [QueuePtrW-1:0]   rd_ptr;
  logic [QueueCntW-1:0]   count;

  assign full      = (count == QueueCntW'(QueueDepth));
  assign not_empty = (count != '0);
  assign head_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

>>> rtl/smfp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack map frame parser back
// Walks the table one byte per cycle when no result stalls; holds each finished frame result.
// ----------------------------------------------------------------------------
module smfp_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  input  smfp_pkg::smfp_item_t   item,
  output logic                   item_pop,
  output logic                   res_valid,
  input  logic                   res_ready,
  output smfp_pkg::smfp_result_t res
);
  import smfp_pkg::*;

  phase_t      phase, phase_next, phase_eff;
  logic [15:0] frames_left, frames_left_next;
  logic [15:0] frame_counter, frame_counter_next;
  logic [15:0] held_delta, held_delta_next;
  logic [15:0] entries_left, entries_left_next;
  logic        in_stack, in_stack_next;
  frame_kind_t held_kind, held_kind_next;
  logic [7:0]  held_tag, held_tag_next;
  logic [16:0] entry_total, entry_total_next;
  logic        bad_seen, bad_seen_next;
  logic [1:0]  skip_bytes, skip_bytes_next;

  logic        emit;
  logic [15:0] el_dec;
  logic        entry_emit;
  logic        entry_more;
  logic        last_frame;
  logic [7:0]  append_cnt;

  // A byte moves on when the result slot is free or is emptied this cycle.
  assign item_pop  = item_valid && (!res_valid || res_ready);
  // A table start forces the count high byte regardless of the held phase.
  assign phase_eff = item.start ? PH_CNT_HI : phase;

  assign el_dec     = entries_left - 16'd1;
  assign entry_more = (el_dec != '0);
  assign entry_emit = !entry_more && !((held_kind == KIND_FULL) && !in_stack);
  assign last_frame = (frames_left == 16'd1);
  assign append_cnt = held_tag - TagSameExt;

  // Which bytes finish a frame.
  always_comb begin
    emit = 1'b0;
    case (phase_eff)
      PH_TAG:      emit = (item.tag_kind == KIND_SAME) || (item.tag_kind == KIND_INVALID);
      PH_DELTA_LO: emit = (held_kind == KIND_CHOP) || (held_kind == KIND_SAME_EXT);
      PH_NSTK_LO:  emit = ({entries_left[15:8], item.data} == '0);
      PH_VTAG:     emit = !item.vt_ext && entry_emit;
      PH_VSKIP:    emit = (skip_bytes == 2'd1) && entry_emit;
      default:     emit = 1'b0;
    endcase
  end

  // Next phase.
  always_comb begin
    phase_next = phase_eff;
    case (phase_eff)
      PH_CNT_HI:   phase_next = PH_CNT_LO;
      PH_CNT_LO:   phase_next = ({frames_left[15:8], item.data} == '0) ? PH_IDLE : PH_TAG;
      PH_TAG: begin
        if (item.tag_kind == KIND_LOC1) phase_next = PH_VTAG;
        else                            phase_next = PH_DELTA_HI;
      end
      PH_DELTA_HI: phase_next = PH_DELTA_LO;
      PH_DELTA_LO: begin
        if (held_kind == KIND_FULL) phase_next = PH_NLOC_HI;
        else                        phase_next = PH_VTAG;
      end
      PH_NLOC_HI:  phase_next = PH_NLOC_LO;
      PH_NLOC_LO:  phase_next = ({entries_left[15:8], item.data} == '0) ? PH_NSTK_HI : PH_VTAG;
      PH_NSTK_HI:  phase_next = PH_NSTK_LO;
      PH_NSTK_LO:  phase_next = PH_VTAG;
      PH_VTAG: begin
        if (item.vt_ext)     phase_next = PH_VSKIP;
        else if (entry_more) phase_next = PH_VTAG;
        else                 phase_next = PH_NSTK_HI;
      end
      PH_VSKIP: begin
        if (skip_bytes != 2'd1) phase_next = PH_VSKIP;
        else if (entry_more)    phase_next = PH_VTAG;
        else                    phase_next = PH_NSTK_HI;
      end
      PH_IDLE:     phase_next = PH_IDLE;
      default:     phase_next = PH_IDLE;
    endcase
    if (emit) phase_next = last_frame ? PH_IDLE : PH_TAG;
  end

  // Data registers.
  always_comb begin
    frames_left_next   = frames_left;
    frame_counter_next = frame_counter;
    held_delta_next    = held_delta;
    entries_left_next  = entries_left;
    in_stack_next      = in_stack;
    held_kind_next     = held_kind;
    held_tag_next      = held_tag;
    entry_total_next   = entry_total;
    bad_seen_next      = bad_seen;
    skip_bytes_next    = skip_bytes;
    case (phase_eff)
      PH_CNT_HI: frames_left_next = {item.data, 8'h00};
      PH_CNT_LO: begin
        frames_left_next   = {frames_left[15:8], item.data};
        frame_counter_next = '0;
      end
      PH_TAG: begin
        held_tag_next     = item.data;
        held_kind_next    = item.tag_kind;
        entry_total_next  = '0;
        bad_seen_next     = 1'b0;
        in_stack_next     = 1'b0;
        skip_bytes_next   = '0;
        entries_left_next = (item.tag_kind == KIND_LOC1) ? 16'd1 : 16'd0;
        if (item.tag_kind == KIND_SAME)      held_delta_next = {8'h00, item.data};
        else if (item.tag_kind == KIND_LOC1) held_delta_next = {10'd0, item.data[5:0]};
        else                                 held_delta_next = '0;
      end
      PH_DELTA_HI: held_delta_next = {item.data, 8'h00};
      PH_DELTA_LO: begin
        held_delta_next = {held_delta[15:8], item.data};
        if (held_kind == KIND_LOC1_EXT)    entries_left_next = 16'd1;
        else if (held_kind == KIND_APPEND) entries_left_next = {8'h00, append_cnt};
      end
      PH_NLOC_HI: entries_left_next = {item.data, 8'h00};
      PH_NLOC_LO: entries_left_next = {entries_left[15:8], item.data};
      PH_NSTK_HI: begin
        in_stack_next     = 1'b1;
        entries_left_next = {item.data, 8'h00};
      end
      PH_NSTK_LO: entries_left_next = {entries_left[15:8], item.data};
      PH_VTAG: begin
        entry_total_next = entry_total + 17'd1;
        if (item.vt_bad) bad_seen_next = 1'b1;
        if (item.vt_ext) skip_bytes_next   = 2'd2;
        else             entries_left_next = el_dec;
      end
      PH_VSKIP: begin
        skip_bytes_next = skip_bytes - 2'd1;
        if (skip_bytes == 2'd1) entries_left_next = el_dec;
      end
      default: ;
    endcase
    if (emit) begin
      frames_left_next   = frames_left - 16'd1;
      frame_counter_next = frame_counter + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_CNT_HI;
      frames_left   <= '0;
      frame_counter <= '0;
      held_delta    <= '0;
      entries_left  <= '0;
      in_stack      <= 1'b0;
      held_kind     <= KIND_SAME;
      held_tag      <= '0;
      entry_total   <= '0;
      bad_seen      <= 1'b0;
      skip_bytes    <= '0;
    end else if (item_pop) begin
      phase         <= phase_next;
      frames_left   <= frames_left_next;
      frame_counter <= frame_counter_next;
      held_delta    <= held_delta_next;
      entries_left  <= entries_left_next;
      in_stack      <= in_stack_next;
      held_kind     <= held_kind_next;
      held_tag      <= held_tag_next;
      entry_total   <= entry_total_next;
      bad_seen      <= bad_seen_next;
      skip_bytes    <= skip_bytes_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (item_pop && emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop && emit) begin
      res.kind    <= held_kind_next;
      res.tag     <= held_tag_next;
      res.delta   <= held_delta_next;
      res.index   <= frame_counter;
      res.entries <= entry_total_next;
      res.bad     <= bad_seen_next;
      res.last    <= last_frame;
    end
  end

endmodule

>>> rtl/smfp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack map frame parser checker
// Port-level properties of the parser results, bound to the top level.
// ----------------------------------------------------------------------------
module smfp_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic [3:0]  m_tuser,
  input logic        m_tlast
);
  import smfp_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled result changed");

  a_same_frame: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[2:0] == KIND_SAME) |->
      (m_tdata[23:8] == {8'h00, m_tdata[7:0]}) && (m_tdata[56:40] == '0) && !m_tuser[3])
    else $error("same frame with wrong delta or entries");

  a_invalid_frame: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[2:0] == KIND_INVALID) |->
      (m_tdata[23:8] == '0) && (m_tdata[56:40] == '0) && !m_tuser[3])
    else $error("reserved tag frame carries data");

  a_loc1_frame: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[2:0] == KIND_LOC1) |->
      (m_tdata[56:40] == 17'd1) && (m_tdata[23:8] == {10'd0, m_tdata[5:0]}))
    else $error("one-stack frame with wrong entries or delta");

endmodule

bind stack_map_frame_parser_unit smfp_checker u_smfp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
